@@ hdl/swaa_pkg.sv @@
// ============================================================================
// swaa_pkg
// Shared types and constants for the sensor window average alarm.
// ============================================================================
package swaa_pkg;

    localparam int TEMP_W = 16;
    localparam int ID_W   = 16;
    localparam int TIME_W = 32;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [2:0] {
        ST_LOADED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_CLEARED = 3'd2,
        ST_INVALID = 3'd3,
        ST_FILLING = 3'd4,
        ST_NORMAL  = 3'd5,
        ST_HOT     = 3'd6,
        ST_COLD    = 3'd7
    } t_status;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_TEMP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TEMP = 2'd1;

    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 16'sd2560;  // 10.0
    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 16'sd5120;  // 20.0

    // sequencer states
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_APP    = 11'b000_0000_0010,
        S_CLR    = 11'b000_0000_0100,
        S_SRD    = 11'b000_0000_1000,
        S_SCMP   = 11'b000_0001_0000,
        S_WR     = 11'b000_0010_0000,
        S_SUMRD  = 11'b000_0100_0000,
        S_SUMACC = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_DWAIT  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

endpackage

@@ hdl/swaa_div.sv @@
// ============================================================================
// swaa_div
// Signed divide by a constant, quotient truncated toward zero.
// ============================================================================
// The magnitude is multiplied by M = ceil(2^K / DIVISOR) and shifted down by K,
// with K = SUM_W + clog2(DIVISOR). This is exact for every magnitude below
// 2^SUM_W. The sign is put back on the truncated magnitude. The magnitude and sign
// are registered first, then the product's upper bits. o_done pulses when the quotient
// is ready.
module swaa_div #(
    parameter int DIVISOR = 5,
    parameter int SUM_W   = 19
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quotient
);

    localparam int RECIP_SH = SUM_W + $clog2(DIVISOR);
    localparam int PROD_W   = SUM_W + RECIP_SH;
    localparam longint unsigned ONE_SH = 64'd1 << RECIP_SH;
    localparam longint unsigned RECIP  = (ONE_SH + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);

    logic [1:0]        r_stage;
    logic              r_neg;
    logic [SUM_W-1:0]  r_mag;
    logic [SUM_W-1:0]  r_q;
    logic [PROD_W-1:0] prod;

    always_comb begin
        prod = PROD_W'(r_mag) * RECIP_C;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_mag <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
        end
        if (r_stage[0]) begin
            r_q <= prod[RECIP_SH +: SUM_W];
        end
    end

    assign o_done     = r_stage[1];
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

@@ hdl/sensor_window_average_alarm.sv @@
// ============================================================================
// sensor_window_average_alarm
// Sensor-to-room map with a per-sensor moving-average temperature alarm.
// ============================================================================
// Input words (i_valid/o_ready) are clear, append map entry or sample. Each
// word gives exactly one result word on o_valid/i_ready. A new word is taken
// only after the previous result has been taken, so a stalled receiver holds
// off the input side. min_temp/max_temp must be written through i_cfg_* only while idle;
// the block does not enforce this. Steps from input accept to the result:
//   clear, reserved kind, append to full table: result directly
//   append: table entry written, then the new window zeroed, one sample a cycle
//   sample: table read and compare per entry up to the match (or entry_count);
//     a full window then adds the window sum, the reciprocal-multiply divide and classify.
//   The block is ready again in the cycle after its result is taken.
// The table scan (a read and a compare per entry on the table memory port) and the
// window sum set the rate. Reset empties the table and loads the threshold
// defaults. No memory clearing pass is needed, because an entry's window and
// position are cleared when the entry is appended.
// ============================================================================
module sensor_window_average_alarm #(
    parameter int MAX_SENSORS = 16,
    parameter int WINDOW_LEN  = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [swaa_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [swaa_pkg::TEMP_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_kind,
    input  logic [swaa_pkg::ID_W-1:0]             i_sensor_id,
    input  logic [swaa_pkg::ID_W-1:0]             i_room_id,
    input  logic signed [swaa_pkg::TEMP_W-1:0]    i_sample_value,
    input  logic [swaa_pkg::TIME_W-1:0]           i_sample_time,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output swaa_pkg::t_status                     o_status,
    output logic [swaa_pkg::ID_W-1:0]             o_out_sensor_id,
    output logic [swaa_pkg::ID_W-1:0]             o_out_room_id,
    output logic signed [swaa_pkg::TEMP_W-1:0]    o_average,
    output logic [swaa_pkg::TIME_W-1:0]           o_out_time
);

    import swaa_pkg::*;

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int J_W   = POS_W + 1;
    localparam int WIN_D = MAX_SENSORS * WINDOW_LEN;
    localparam int WA_W  = (WIN_D > 1) ? $clog2(WIN_D) : 1;
    localparam int SUM_W = TEMP_W + $clog2(WINDOW_LEN);

    typedef struct packed {
        logic             full;
        logic [POS_W-1:0] pos;
    } t_pos_ent;

    // memories
    logic [2*ID_W-1:0]        mem_tab [MAX_SENSORS];
    t_pos_ent                 mem_pos [MAX_SENSORS];
    logic signed [TEMP_W-1:0] mem_win [WIN_D];

    t_state                   r_state, n_state;
    logic signed [TEMP_W-1:0] r_min_temp, r_max_temp;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic [J_W-1:0]           r_j;
    logic [WA_W-1:0]          r_base;
    logic signed [SUM_W-1:0]  r_acc;

    logic [2*ID_W-1:0]        r_tab_q;
    t_pos_ent                 r_pos_q;
    logic signed [TEMP_W-1:0] r_win_q;

    // latched item
    logic [ID_W-1:0]          r_sid;
    logic [ID_W-1:0]          r_rid;
    logic signed [TEMP_W-1:0] r_sample;

    // result register
    t_status                  r_status;
    logic [ID_W-1:0]          r_room;
    logic signed [TEMP_W-1:0] r_avg;
    logic [TIME_W-1:0]        r_time;

    logic                     in_acc;
    logic [J_W-1:0]           p_eff;
    logic [J_W-1:0]           p_inc;
    logic                     p_wrap;
    t_pos_ent                 n_pos;
    logic                     win_we;
    logic [WA_W-1:0]          win_waddr;
    logic signed [TEMP_W-1:0] win_wdata;
    logic [WA_W-1:0]          win_raddr;
    logic                     id_match;
    logic                     last_j;

    logic                     div_done;
    logic signed [SUM_W-1:0]  div_quot;
    logic signed [TEMP_W-1:0] avg_w;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && o_ready;

    // write position update for a sample
    always_comb begin
        p_eff  = (J_W'(r_pos_q.pos) >= J_W'(WINDOW_LEN)) ? '0 : J_W'(r_pos_q.pos);
        p_inc  = p_eff + J_W'(1);
        p_wrap = (p_inc == J_W'(WINDOW_LEN));
        n_pos.full = r_pos_q.full | p_wrap;
        n_pos.pos  = p_wrap ? '0 : p_inc[POS_W-1:0];
    end

    assign id_match  = (r_tab_q[2*ID_W-1:ID_W] == r_sid);
    assign last_j    = (r_j == J_W'(WINDOW_LEN - 1));
    assign win_we    = (r_state == S_CLR) || (r_state == S_WR);
    assign win_waddr = r_base + WA_W'((r_state == S_CLR) ? r_j : p_eff);
    assign win_wdata = (r_state == S_CLR) ? '0 : r_sample;
    assign win_raddr = r_base + WA_W'(r_j);
    assign avg_w     = div_quot[TEMP_W-1:0];

    swaa_div #(
        .DIVISOR (WINDOW_LEN),
        .SUM_W   (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV),
        .i_dividend (r_acc),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        KIND_APPEND: n_state = (r_count >= CNT_W'(MAX_SENSORS)) ? S_OUT : S_APP;
                        KIND_SAMPLE: n_state = S_SRD;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_APP:    n_state = S_CLR;
            S_CLR:    n_state = last_j ? S_OUT : S_CLR;
            S_SRD:    n_state = (r_idx >= r_count) ? S_OUT : S_SCMP;
            S_SCMP:   n_state = id_match ? S_WR : S_SRD;
            S_WR:     n_state = n_pos.full ? S_SUMRD : S_OUT;
            S_SUMRD:  n_state = S_SUMACC;
            S_SUMACC: n_state = last_j ? S_DIV : S_SUMRD;
            S_DIV:    n_state = S_DWAIT;
            S_DWAIT:  n_state = div_done ? S_OUT : S_DWAIT;
            S_OUT:    n_state = i_ready ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_min_temp <= MIN_TEMP_RST;
            r_max_temp <= MAX_TEMP_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_TEMP: r_min_temp <= i_cfg_data;
                    CFG_MAX_TEMP: r_max_temp <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && (i_kind == KIND_CLEAR)) begin
                r_count <= '0;
            end else if ((r_state == S_CLR) && last_j) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // datapath and result word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sid    <= i_sensor_id;
                r_rid    <= i_room_id;
                r_sample <= i_sample_value;
                r_room   <= '0;
                r_avg    <= '0;
                r_time   <= (i_kind == KIND_SAMPLE) ? i_sample_time : '0;
                r_idx    <= (i_kind == KIND_APPEND) ? r_count : '0;
                r_j      <= '0;
                r_acc    <= '0;
                case (i_kind)
                    KIND_CLEAR:  r_status <= ST_CLEARED;
                    KIND_APPEND: r_status <= ST_FULL;
                    default:     r_status <= ST_INVALID;
                endcase
            end
            S_APP: begin
                r_base <= WA_W'(r_idx[IDX_W-1:0] * WINDOW_LEN);
            end
            S_CLR: begin
                r_j <= r_j + J_W'(1);
                if (last_j) begin
                    r_status <= ST_LOADED;
                    r_room   <= r_rid;
                end
            end
            S_SCMP: begin
                if (id_match) begin
                    r_base <= WA_W'(r_idx[IDX_W-1:0] * WINDOW_LEN);
                    r_room <= r_tab_q[ID_W-1:0];
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            S_WR: begin
                r_status <= ST_FILLING;
                r_j      <= '0;
            end
            S_SUMACC: begin
                r_acc <= r_acc + SUM_W'(r_win_q);
                r_j   <= r_j + J_W'(1);
            end
            S_DWAIT: begin
                if (div_done) begin
                    r_avg <= avg_w;
                    if (avg_w > r_max_temp) begin
                        r_status <= ST_HOT;
                    end else if (avg_w < r_min_temp) begin
                        r_status <= ST_COLD;
                    end else begin
                        r_status <= ST_NORMAL;
                    end
                end
            end
            default: ;
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_APP) begin
            mem_tab[r_idx[IDX_W-1:0]] <= {r_sid, r_rid};
        end
        r_tab_q <= mem_tab[r_idx[IDX_W-1:0]];
    end

    // write position / full flag memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_APP) begin
            mem_pos[r_idx[IDX_W-1:0]] <= '0;
        end else if (r_state == S_WR) begin
            mem_pos[r_idx[IDX_W-1:0]] <= n_pos;
        end
        r_pos_q <= mem_pos[r_idx[IDX_W-1:0]];
    end

    // window sample memory
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            mem_win[win_waddr] <= win_wdata;
        end
        r_win_q <= mem_win[win_raddr];
    end

    assign o_status        = r_status;
    assign o_out_sensor_id = r_sid;
    assign o_out_room_id   = r_room;
    assign o_average       = r_avg;
    assign o_out_time      = r_time;

    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SENSORS))
        else $error("entry count above table size");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> (r_idx < r_count))
        else $error("table compare beyond entry count");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside wait state");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == KIND_CLEAR)) |=> (r_count == '0))
        else $error("clear word did not empty the table");

    a_full_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_kind == KIND_APPEND) && (r_count >= CNT_W'(MAX_SENSORS)))
        |=> (o_valid && (r_status == ST_FULL) && $stable(r_count)))
        else $error("append to full table changed state");

endmodule
